// ----- hdl/hsv_pkg.sv -----
// ----------------------------------------------------------------------------
// hsv_pkg
// shared widths, angle constants and the cordic arctangent table
// ----------------------------------------------------------------------------
package hsv_pkg;

  localparam int CORDIC_STEPS = 26;
  localparam int XY_W         = 29;
  localparam int Z_W          = 35;
  localparam int DIV_W        = 26;
  localparam int ANG_BITS     = 30;
  localparam int PIPE_LATENCY = CORDIC_STEPS + 2;

  localparam logic signed [Z_W-1:0] HALF_PI_Q30 = 35'sd1686629713;
  localparam logic signed [Z_W-1:0] PI_Q30      = 35'sd3373259426;
  localparam logic signed [Z_W-1:0] TWO_PI_Q30  = 35'sd6746518852;
  localparam logic [24:0]           SQRT3_Q16   = 25'd113512;
  // ceil(2^23 / 255), exact for 15-bit dividends
  localparam logic [30:0]           RECIP_255   = 31'd32897;

  typedef struct packed {
    logic        gray;
    logic        flip;
    logic        black;
    logic [15:0] bri;
  } tag_t;

  function automatic logic signed [Z_W-1:0] atan_q30(input int i);
    logic signed [Z_W-1:0] a;
    case (i)
      0:       a = 35'sd843314857;
      1:       a = 35'sd497837829;
      2:       a = 35'sd263043837;
      3:       a = 35'sd133525159;
      4:       a = 35'sd67021687;
      5:       a = 35'sd33543516;
      6:       a = 35'sd16775851;
      7:       a = 35'sd8388437;
      8:       a = 35'sd4194283;
      9:       a = 35'sd2097149;
      10:      a = 35'sd1048576;
      11:      a = 35'sd524288;
      12:      a = 35'sd262144;
      13:      a = 35'sd131072;
      14:      a = 35'sd65536;
      15:      a = 35'sd32768;
      16:      a = 35'sd16384;
      17:      a = 35'sd8192;
      18:      a = 35'sd4096;
      19:      a = 35'sd2048;
      20:      a = 35'sd1024;
      21:      a = 35'sd512;
      22:      a = 35'sd256;
      23:      a = 35'sd128;
      24:      a = 35'sd64;
      25:      a = 35'sd32;
      default: a = '0;
    endcase
    return a;
  endfunction

endpackage

// ----- hdl/hsv_front.sv -----
// ----------------------------------------------------------------------------
// hsv_front
// input stage: max/min, hue vector with quadrant pre-rotation, divider operands
// ----------------------------------------------------------------------------
module hsv_front (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  input  logic [7:0]                          red,
  input  logic [7:0]                          green,
  input  logic [7:0]                          blue,
  output logic                                valid_r,
  output logic signed [hsv_pkg::XY_W-1:0]     x_r,
  output logic signed [hsv_pkg::XY_W-1:0]     y_r,
  output logic signed [hsv_pkg::Z_W-1:0]      z_r,
  output hsv_pkg::tag_t                       tag_r,
  output logic [7:0]                          mx_r,
  output logic [hsv_pkg::DIV_W-1:0]           satn_r
);

  logic [7:0]                      mx, mn, ad;
  logic signed [10:0]              diff;
  logic signed [hsv_pkg::XY_W-1:0] x0, y0, x_nxt, y_nxt;
  logic signed [hsv_pkg::Z_W-1:0]  z_nxt;
  logic [24:0]                     yprod;
  logic [14:0]                     bn;
  logic [30:0]                     bprod;
  hsv_pkg::tag_t                   tag_nxt;

  always_comb begin
    mx = red;
    mn = red;
    if (green > mx) mx = green;
    if (blue > mx) mx = blue;
    if (green < mn) mn = green;
    if (blue < mn) mn = blue;
    diff  = $signed({2'b00, red, 1'b0}) - $signed({3'b000, green})
            - $signed({3'b000, blue});
    ad    = (green >= blue) ? (green - blue) : (blue - green);
    yprod = {17'd0, ad} * hsv_pkg::SQRT3_Q16;
    x0    = {{(hsv_pkg::XY_W-27){diff[10]}}, diff, 16'd0};
    y0    = {{(hsv_pkg::XY_W-25){1'b0}}, yprod};
    // left half plane: turn by -pi/2 first
    if (x0 < 0) begin
      x_nxt = y0;
      y_nxt = -x0;
      z_nxt = hsv_pkg::HALF_PI_Q30;
    end else begin
      x_nxt = x0;
      y_nxt = y0;
      z_nxt = '0;
    end
    // value: max*32768 = 128*255*max + 128*max, so only 128*max+127 is divided
    bn    = {mx, 7'd0} + 15'd127;
    bprod = {16'd0, bn} * hsv_pkg::RECIP_255;
    tag_nxt.gray  = (red == green) && (green == blue);
    tag_nxt.flip  = blue > green;
    tag_nxt.black = mx == 8'd0;
    tag_nxt.bri   = {1'b0, mx, 7'd0} + {8'd0, bprod[30:23]};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= in_valid;
    end
    x_r    <= x_nxt;
    y_r    <= y_nxt;
    z_r    <= z_nxt;
    tag_r  <= tag_nxt;
    mx_r   <= mx;
    satn_r <= {3'd0, mx - mn, 15'd0} + {19'd0, mx[7:1]};
  end

endmodule

// ----- hdl/hsv_cordic.sv -----
// ----------------------------------------------------------------------------
// hsv_cordic
// vectoring cordic, one micro-rotation per register stage
// ----------------------------------------------------------------------------
module hsv_cordic (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            valid_i,
  input  logic signed [hsv_pkg::XY_W-1:0] x_i,
  input  logic signed [hsv_pkg::XY_W-1:0] y_i,
  input  logic signed [hsv_pkg::Z_W-1:0]  z_i,
  input  hsv_pkg::tag_t                   tag_i,
  output logic                            valid_o,
  output logic signed [hsv_pkg::Z_W-1:0]  z_o,
  output hsv_pkg::tag_t                   tag_o
);

  localparam int N = hsv_pkg::CORDIC_STEPS;

  logic                            vld_r [0:N];
  logic signed [hsv_pkg::XY_W-1:0] x_r   [0:N];
  logic signed [hsv_pkg::XY_W-1:0] y_r   [0:N];
  logic signed [hsv_pkg::Z_W-1:0]  z_r   [0:N];
  hsv_pkg::tag_t                   tag_r [0:N];

  always_comb begin
    vld_r[0] = valid_i;
    x_r[0]   = x_i;
    y_r[0]   = y_i;
    z_r[0]   = z_i;
    tag_r[0] = tag_i;
  end

  for (genvar i = 0; i < N; i++) begin : g_stage
    logic signed [hsv_pkg::XY_W-1:0] dx, dy;
    assign dx = y_r[i] >>> i;
    assign dy = x_r[i] >>> i;

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[i+1] <= 1'b0;
      end else begin
        vld_r[i+1] <= vld_r[i];
      end
      tag_r[i+1] <= tag_r[i];
      if (y_r[i] > 0) begin
        x_r[i+1] <= x_r[i] + dx;
        y_r[i+1] <= y_r[i] - dy;
        z_r[i+1] <= z_r[i] + hsv_pkg::atan_q30(i);
      end else begin
        x_r[i+1] <= x_r[i] - dx;
        y_r[i+1] <= y_r[i] + dy;
        z_r[i+1] <= z_r[i] - hsv_pkg::atan_q30(i);
      end
    end
  end

  assign valid_o = vld_r[N];
  assign z_o     = z_r[N];
  assign tag_o   = tag_r[N];

endmodule

// ----- hdl/hsv_div.sv -----
// ----------------------------------------------------------------------------
// hsv_div
// pipelined restoring divider, one quotient bit per stage, 8-bit divisor
// ----------------------------------------------------------------------------
module hsv_div (
  input  logic                       clk,
  input  logic [hsv_pkg::DIV_W-1:0]  num_i,
  input  logic [7:0]                 den_i,
  output logic [15:0]                quo_o
);

  localparam int N = hsv_pkg::DIV_W;

  logic [7:0]   rem_r [0:N];
  logic [N-1:0] num_r [0:N];
  logic [N-1:0] quo_r [0:N];
  logic [7:0]   den_r [0:N];

  always_comb begin
    rem_r[0] = '0;
    num_r[0] = num_i;
    quo_r[0] = '0;
    den_r[0] = den_i;
  end

  for (genvar i = 0; i < N; i++) begin : g_stage
    logic [8:0] t, d;
    logic       ge;
    assign t  = {rem_r[i], num_r[i][N-1]};
    assign d  = {1'b0, den_r[i]};
    assign ge = t >= d;

    always_ff @(posedge clk) begin
      rem_r[i+1] <= ge ? 8'(t - d) : t[7:0];
      num_r[i+1] <= {num_r[i][N-2:0], 1'b0};
      quo_r[i+1] <= {quo_r[i][N-2:0], ge};
      den_r[i+1] <= den_r[i];
    end
  end

  assign quo_o = quo_r[N][15:0];

endmodule

// ----- hdl/rgb_to_hsv_pixel_convert_core.sv -----
// ----------------------------------------------------------------------------
// rgb_to_hsv_pixel_convert_core
// rgb pixel to hue (hsi arc-cosine form), saturation and value
// ----------------------------------------------------------------------------
// usage:
//   an item (in_red, in_green, in_blue) is taken on any clock edge where
//   start is high; busy stays low, so one pixel can enter every cycle.
//   each result appears on the out_ ports for one cycle with out_valid high
//   and results leave in the order their items were taken. an item passes
//   through one input register, the 26 cordic micro-rotation stages
//   (the saturation divider runs beside them, one quotient bit per stage;
//   value is a reciprocal multiply in the input stage carried alongside)
//   and one output register. throughput is one item per cycle.
//   out_hue is radians in unsigned fixed point with HUE_FRAC_BITS fraction
//   bits; gray pixels give hue 0 with out_hue_undefined high.
//   synchronous reset clears all valid bits, so nothing in flight comes out.
//   the receiver cannot stall; results are strobed, never held.
// ----------------------------------------------------------------------------
module rgb_to_hsv_pixel_convert_core #(
  parameter int HUE_FRAC_BITS = 13
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [7:0]  in_red,
  input  logic [7:0]  in_green,
  input  logic [7:0]  in_blue,
  output logic        out_valid,
  output logic [15:0] out_hue,
  output logic [15:0] out_saturation,
  output logic [15:0] out_brightness,
  output logic        out_hue_undefined
);

  localparam int ZW = hsv_pkg::Z_W;
  localparam int SH = hsv_pkg::ANG_BITS - HUE_FRAC_BITS;

  logic                   f_valid;
  logic signed [hsv_pkg::XY_W-1:0] f_x, f_y;
  logic signed [ZW-1:0]   f_z;
  hsv_pkg::tag_t          f_tag;
  logic [7:0]             f_mx;
  logic [hsv_pkg::DIV_W-1:0] f_satn;

  logic                   c_valid;
  logic signed [ZW-1:0]   c_z;
  hsv_pkg::tag_t          c_tag;
  logic [15:0]            sat_q;

  logic signed [ZW-1:0]   theta;
  logic [ZW-1:0]          h, hr, hq;
  logic [15:0]            hue_nxt;

  logic                   valid_r;
  logic [15:0]            hue_r, sat_r, bri_r;
  logic                   undef_r;

  assign busy = 1'b0;

  hsv_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_valid(start),
    .red     (in_red),
    .green   (in_green),
    .blue    (in_blue),
    .valid_r (f_valid),
    .x_r     (f_x),
    .y_r     (f_y),
    .z_r     (f_z),
    .tag_r   (f_tag),
    .mx_r    (f_mx),
    .satn_r  (f_satn)
  );

  hsv_cordic u_cordic (
    .clk    (clk),
    .rst_n  (rst_n),
    .valid_i(f_valid),
    .x_i    (f_x),
    .y_i    (f_y),
    .z_i    (f_z),
    .tag_i  (f_tag),
    .valid_o(c_valid),
    .z_o    (c_z),
    .tag_o  (c_tag)
  );

  hsv_div u_sat_div (
    .clk  (clk),
    .num_i(f_satn),
    .den_i(f_mx),
    .quo_o(sat_q)
  );

  always_comb begin
    theta = c_z;
    if (c_z < 0) theta = '0;
    if (c_z > hsv_pkg::PI_Q30) theta = hsv_pkg::PI_Q30;
    h  = c_tag.flip ? ZW'(hsv_pkg::TWO_PI_Q30 - theta) : ZW'(theta);
    // round half up to the output fraction width
    hr = h + (ZW'(1) << (SH - 1));
    hq = hr >> SH;
    if (c_tag.gray) begin
      hue_nxt = '0;
    end else if (hq > ZW'(16'hFFFF)) begin
      hue_nxt = 16'hFFFF;
    end else begin
      hue_nxt = hq[15:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= c_valid;
    end
    hue_r   <= hue_nxt;
    sat_r   <= c_tag.black ? 16'd0 : sat_q;
    bri_r   <= c_tag.bri;
    undef_r <= c_tag.gray;
  end

  assign out_valid         = valid_r;
  assign out_hue           = hue_r;
  assign out_saturation    = sat_r;
  assign out_brightness    = bri_r;
  assign out_hue_undefined = undef_r;

endmodule

// ----- hdl/hsv_checker.sv -----
// ----------------------------------------------------------------------------
// hsv_checker
// port-level checks on item timing, result ranges and gray/black results
// ----------------------------------------------------------------------------
module hsv_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        start,
  input logic        busy,
  input logic        out_valid,
  input logic [15:0] out_hue,
  input logic [15:0] out_saturation,
  input logic [15:0] out_brightness,
  input logic        out_hue_undefined
);

  localparam int LAT = hsv_pkg::PIPE_LATENCY;

  // every item taken comes out after the fixed latency
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |-> ##LAT out_valid)
    else $error("item lost in pipeline");

  // no result without an item taken
  a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(start && !busy && rst_n, LAT))
    else $error("result without item");

  a_gray_hue: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_hue_undefined |-> out_hue == 16'd0)
    else $error("gray pixel with nonzero hue");

  a_black_sat: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_brightness == 16'd0 |-> out_saturation == 16'd0)
    else $error("black pixel with nonzero saturation");

  a_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_saturation <= 16'd32768 && out_brightness <= 16'd32768)
    else $error("saturation or value above one");

endmodule

bind rgb_to_hsv_pixel_convert_core hsv_checker u_hsv_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .start            (start),
  .busy             (busy),
  .out_valid        (out_valid),
  .out_hue          (out_hue),
  .out_saturation   (out_saturation),
  .out_brightness   (out_brightness),
  .out_hue_undefined(out_hue_undefined)
);

// ----- bench/rgb_to_hsv_pixel_convert_core_tb.sv -----
// ----------------------------------------------------------------------------
// rgb_to_hsv_pixel_convert_core_tb
// drives rgb pixels through the converter and checks every result against an
// in-bench cordic model of hue, saturation and value, in order of acceptance
// ----------------------------------------------------------------------------
module rgb_to_hsv_pixel_convert_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int HUE_FRAC   = 13;
  localparam int WD_LIMIT   = 2000;
  localparam int N_RANDOM   = 1200;
  localparam int N_DIRECTED = 20;

  typedef struct packed {
    logic [15:0] hue;
    logic [15:0] sat;
    logic [15:0] bri;
    logic        undef;
  } hsv_t;

  typedef struct packed {
    logic [23:0] px;
    logic        typed;
    hsv_t        exp;
  } dir_row_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        start = 1'b0;
  logic        busy;
  logic [7:0]  in_red = '0;
  logic [7:0]  in_green = '0;
  logic [7:0]  in_blue = '0;
  logic        out_valid;
  logic [15:0] out_hue;
  logic [15:0] out_saturation;
  logic [15:0] out_brightness;
  logic        out_hue_undefined;

  hsv_t pending_hsv[$];
  int   n_errors = 0;
  int   idle_cycles = 0;
  int   send_idle_pct = 8;

  always #1 clk = ~clk;

  rgb_to_hsv_pixel_convert_core #(.HUE_FRAC_BITS(HUE_FRAC)) u_top (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_red(in_red), .in_green(in_green), .in_blue(in_blue),
    .out_valid(out_valid), .out_hue(out_hue), .out_saturation(out_saturation),
    .out_brightness(out_brightness), .out_hue_undefined(out_hue_undefined)
  );

  function automatic longint floor_shr(longint v, int s);
    return v >>> s;
  endfunction

  function automatic hsv_t convert_pixel(logic [7:0] r8, logic [7:0] g8, logic [7:0] b8);
    hsv_t   res;
    longint r, g, b, mx, mn, x, y, z, t, dx, dy, h, rounded;
    int     sh;
    r = r8; g = g8; b = b8;
    mx = r; mn = r;
    if (g > mx) mx = g;
    if (b > mx) mx = b;
    if (g < mn) mn = g;
    if (b < mn) mn = b;
    res.hue = '0;
    res.undef = 1'b0;
    if (r == g && g == b) begin
      res.undef = 1'b1;
    end else begin
      x = (2 * r - g - b) * 65536;
      y = ((g > b) ? g - b : b - g) * longint'(hsv_pkg::SQRT3_Q16);
      z = 0;
      // left half plane: pre-rotate by a quarter turn
      if (x < 0) begin
        t = x; x = y; y = -t;
        z = longint'(hsv_pkg::HALF_PI_Q30);
      end
      for (int i = 0; i < hsv_pkg::CORDIC_STEPS; i++) begin
        dx = floor_shr(y, i);
        dy = floor_shr(x, i);
        if (y > 0) begin
          x = x + dx; y = y - dy; z = z + longint'(hsv_pkg::atan_q30(i));
        end else begin
          x = x - dx; y = y + dy; z = z - longint'(hsv_pkg::atan_q30(i));
        end
      end
      if (z < 0) z = 0;
      if (z > longint'(hsv_pkg::PI_Q30)) z = longint'(hsv_pkg::PI_Q30);
      h = (b <= g) ? z : longint'(hsv_pkg::TWO_PI_Q30) - z;
      sh = hsv_pkg::ANG_BITS - HUE_FRAC;
      rounded = (h + (longint'(1) << (sh - 1))) >> sh;
      res.hue = (rounded > 65535) ? 16'hffff : rounded[15:0];
    end
    res.sat = (mx > 0) ? 16'(((mx - mn) * 32768 + mx / 2) / mx) : 16'd0;
    res.bri = 16'((mx * 32768 + 127) / 255);
    return res;
  endfunction

  // directed pixels: extremes, primaries, secondaries, gray and black
  // gray rows carry their expected result, the rest use the model
  dir_row_t dir_row[N_DIRECTED] = '{
    '{24'h000000, 1'b1, '{16'd0, 16'd0, 16'd0, 1'b1}},
    '{24'hffffff, 1'b1, '{16'd0, 16'd0, 16'd32768, 1'b1}},
    '{24'h808080, 1'b1, '{16'd0, 16'd0, 16'd16448, 1'b1}},
    '{24'h010101, 1'b1, '{16'd0, 16'd0, 16'd129, 1'b1}},
    '{24'hff0000, 1'b0, '0}, '{24'h00ff00, 1'b0, '0}, '{24'h0000ff, 1'b0, '0},
    '{24'hffff00, 1'b0, '0}, '{24'h00ffff, 1'b0, '0}, '{24'hff00ff, 1'b0, '0},
    '{24'hfe0001, 1'b0, '0}, '{24'h01fe00, 1'b0, '0}, '{24'h0001fe, 1'b0, '0},
    '{24'haa55aa, 1'b0, '0}, '{24'h55aa55, 1'b0, '0}, '{24'h7f807f, 1'b0, '0},
    '{24'h000001, 1'b0, '0}, '{24'hff00fe, 1'b0, '0}, '{24'h0100ff, 1'b0, '0},
    '{24'h80ff7f, 1'b0, '0}
  };

  // output side: checked at every edge with out_valid
  always @(posedge clk) begin
    hsv_t exp_hsv;
    if (rst_n && out_valid) begin
      if (pending_hsv.size() == 0) begin
        $error("unexpected result hue=%0d", out_hue);
        n_errors++;
      end else begin
        exp_hsv = pending_hsv.pop_front();
        if (out_hue !== exp_hsv.hue) begin
          $error("hue exp %0d got %0d", exp_hsv.hue, out_hue); n_errors++;
        end
        if (out_saturation !== exp_hsv.sat) begin
          $error("saturation exp %0d got %0d", exp_hsv.sat, out_saturation); n_errors++;
        end
        if (out_brightness !== exp_hsv.bri) begin
          $error("brightness exp %0d got %0d", exp_hsv.bri, out_brightness); n_errors++;
        end
        if (out_hue_undefined !== exp_hsv.undef) begin
          $error("hue_undefined exp %0d got %0d", exp_hsv.undef, out_hue_undefined);
          n_errors++;
        end
      end
    end
  end

  // watchdog on cycles with nothing accepted and no result out
  always @(posedge clk) begin
    if ((start && !busy) || out_valid) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WD_LIMIT) begin
      $display("rgb_to_hsv_pixel_convert_core_tb: errors");
      $finish;
    end
  end

  task automatic send_pixel(logic [23:0] px, hsv_t exp_hsv);
    while ($urandom_range(99, 0) < send_idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start    <= 1'b1;
    in_red   <= px[23:16];
    in_green <= px[15:8];
    in_blue  <= px[7:0];
    @(posedge clk);
    while (busy) @(posedge clk);
    pending_hsv.push_back(exp_hsv);
  endtask

  function automatic logic [23:0] random_pixel();
    logic [7:0] v;
    case ($urandom_range(5, 0))
      0: begin
        v = 8'($urandom); return {v, v, v};
      end
      1: begin
        v = 8'($urandom);
        return {v, v, 8'($urandom)};
      end
      2: return {8'($urandom_range(3, 0)), 8'($urandom_range(3, 0)),
                 8'($urandom_range(3, 0))};
      default: return 24'($urandom);
    endcase
  endfunction

  initial begin
    int          wait_cnt;
    logic [23:0] px;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    for (int i = 0; i < N_DIRECTED; i++) begin
      px = dir_row[i].px;
      send_pixel(px, dir_row[i].typed ? dir_row[i].exp
                                      : convert_pixel(px[23:16], px[15:8], px[7:0]));
    end
    for (int i = 0; i < N_RANDOM; i++) begin
      if (i == N_RANDOM / 3) send_idle_pct = 49;
      if (i == 2 * N_RANDOM / 3) send_idle_pct = 0;
      px = random_pixel();
      send_pixel(px, convert_pixel(px[23:16], px[15:8], px[7:0]));
    end
    start <= 1'b0;
    wait_cnt = 0;
    while (pending_hsv.size() != 0 && wait_cnt < 10 * hsv_pkg::PIPE_LATENCY) begin
      @(posedge clk);
      wait_cnt++;
    end
    repeat (hsv_pkg::PIPE_LATENCY + 4) @(posedge clk);
    if (n_errors == 0 && pending_hsv.size() == 0) begin
      $display("rgb_to_hsv_pixel_convert_core_tb: clean");
    end else begin
      $display("rgb_to_hsv_pixel_convert_core_tb: errors");
    end
    $finish;
  end

endmodule
